### rtl/mshr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mshr_pkg;
  localparam int Depth = 16;
  localparam int SlotW = 4;
  localparam int CntW  = 5;
  localparam int AddrW = 58;
  localparam int DataW = 64;
  localparam int MetaW = 32;
  localparam int CycW  = 48;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFill  = 2'd1;
  localparam logic [1:0] OpDrain = 2'd2;

  localparam logic [2:0] OutAlloc    = 3'd0;
  localparam logic [2:0] OutFull     = 3'd1;
  localparam logic [2:0] OutFillOk   = 3'd2;
  localparam logic [2:0] OutFillMiss = 3'd3;
  localparam logic [2:0] OutDrained  = 3'd4;
  localparam logic [2:0] OutNone     = 3'd5;

  localparam logic [CycW-1:0] CycMax = {CycW{1'b1}};

  typedef struct packed {
    logic latch;      // capture request
    logic do_alloc;
    logic do_fill;
    logic scan_clear; // start min scan
    logic scan_step;
    logic drain_pick; // mark+free current drain slot
    logic drain_step;
    logic emit_pick;  // show marked slot
    logic emit_step;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       free_found;
    logic       match_found;
    logic       drain_hit;   // current drain slot completed
    logic       drain_end;   // cursor at last slot
    logic       room_left;   // room after this pick
    logic       room_zero;
    logic       scan_end;
    logic       pick_hit;    // current slot marked for output
    logic       pick_last;   // no other marked slot left
  } stat_t;
endpackage
`default_nettype wire

### rtl/miss_status_holding_table.sv
// Miss status holding table, 16 slots.
// Request: start_i with payload when busy_o is low; op selects allocate,
// fill return or drain. Results: strobe result_valid_o for one cycle each,
// last_o on the final result of a request. The receiver cannot stall.
// Allocate, unmatched fill, drain with no room and unused op: one result,
// given from the execute state.
// Matched fill: a 16-step serial scan for the earliest ready slot, then the result.
// Drain: cursor walks slots one per cycle (up to 16), freeing and marking
// completed slots; then the 16-step scan; then a second walk, one slot per
// cycle, shows the marked slots, so every result carries final occupancy and
// earliest fields. Nothing completed: one outcome-none result after the full walk.
// busy_o drops with the final strobe; the next request can be taken at the
// edge that takes it.
// Registers via APB: fill_latency at address 0, reset 10.
// Reset clears valid/done bits, occupancy and tracking; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module miss_status_holding_table
  import mshr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [0:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [AddrW-1:0] block_address_i,
  input  wire logic [DataW-1:0] fill_data_i,
  input  wire logic [MetaW-1:0] prefetch_meta_i,
  input  wire logic [CycW-1:0]  request_ready_cycle_i,
  input  wire logic [CycW-1:0]  now_cycle_i,
  input  wire logic [4:0]       queue_room_i,
  output logic                  result_valid_o,
  output logic [2:0]            outcome_o,
  output logic [SlotW-1:0]      slot_o,
  output logic [AddrW-1:0]      entry_address_o,
  output logic [DataW-1:0]      entry_data_o,
  output logic [MetaW-1:0]      entry_meta_o,
  output logic [CycW-1:0]       entry_ready_cycle_o,
  output logic [CntW-1:0]       entries_used_o,
  output logic [CycW-1:0]       earliest_ready_o,
  output logic [CntW-1:0]       earliest_slot_o,
  output logic                  last_o
);
  logic [7:0] lat_q;
  ctrl_t ctrl;
  stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, lat_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lat_q <= 8'd10;
    else if (psel && penable && pwrite && paddr == 1'b0) lat_q <= pwdata[7:0];
  end

  mshr_control u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .stat_i(stat), .ctrl_o(ctrl),
    .valid_o(result_valid_o), .last_o
  );

  mshr_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .op_i, .block_address_i,
    .fill_data_i, .prefetch_meta_i, .request_ready_cycle_i, .now_cycle_i,
    .queue_room_i, .fill_latency_i(lat_q), .outcome_o, .slot_o,
    .entry_address_o, .entry_data_o, .entry_meta_o, .entry_ready_cycle_o,
    .entries_used_o, .earliest_ready_o, .earliest_slot_o
  );
endmodule
`default_nettype wire

### rtl/mshr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mshr_datapath
  import mshr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  output stat_t                 stat_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [AddrW-1:0] block_address_i,
  input  wire logic [DataW-1:0] fill_data_i,
  input  wire logic [MetaW-1:0] prefetch_meta_i,
  input  wire logic [CycW-1:0]  request_ready_cycle_i,
  input  wire logic [CycW-1:0]  now_cycle_i,
  input  wire logic [4:0]       queue_room_i,
  input  wire logic [7:0]       fill_latency_i,
  output logic [2:0]            outcome_o,
  output logic [SlotW-1:0]      slot_o,
  output logic [AddrW-1:0]      entry_address_o,
  output logic [DataW-1:0]      entry_data_o,
  output logic [MetaW-1:0]      entry_meta_o,
  output logic [CycW-1:0]       entry_ready_cycle_o,
  output logic [CntW-1:0]       entries_used_o,
  output logic [CycW-1:0]       earliest_ready_o,
  output logic [CntW-1:0]       earliest_slot_o
);
  logic [Depth-1:0] valid_q, done_q;
  logic [AddrW-1:0] addr_q [Depth];
  logic [DataW-1:0] data_q [Depth];
  logic [MetaW-1:0] meta_q [Depth];
  logic [CycW-1:0]  rdy_q  [Depth];
  logic [CntW-1:0]  used_q;
  logic [CycW-1:0]  soon_q;
  logic [CntW-1:0]  soon_slot_q;
  logic [Depth-1:0] pick_q;

  logic [1:0]       op_q;
  logic [AddrW-1:0] a_q;
  logic [DataW-1:0] d_q;
  logic [MetaW-1:0] m_q;
  logic [CycW-1:0]  req_q, now_q;
  logic [4:0]       room_q;
  logic [SlotW-1:0] cur_q;

  logic [SlotW-1:0] free_idx, match_idx;
  logic             free_f, match_f;
  logic [Depth-1:0] cur_bit;

  always_comb begin
    free_idx = '0; free_f = 1'b0;
    match_idx = '0; match_f = 1'b0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SlotW'(i); free_f = 1'b1;
      end
      if (valid_q[i] && !done_q[i] && addr_q[i] == a_q) begin
        match_idx = SlotW'(i); match_f = 1'b1;
      end
    end
  end

  logic [CycW-1:0] base;
  logic [CycW:0]   sum;
  logic [CycW-1:0] newrdy;
  assign base   = (rdy_q[match_idx] < now_q) ? now_q : rdy_q[match_idx];
  assign sum    = {1'b0, base} + {{(CycW-7){1'b0}}, fill_latency_i};
  assign newrdy = sum[CycW] ? CycMax : sum[CycW-1:0];

  assign cur_bit = Depth'(1) << cur_q;

  assign stat_o.op          = op_q;
  assign stat_o.free_found  = free_f;
  assign stat_o.match_found = match_f;
  assign stat_o.drain_hit   = valid_q[cur_q] && done_q[cur_q];
  assign stat_o.drain_end   = (cur_q == SlotW'(Depth - 1));
  assign stat_o.room_left   = (room_q > 5'd1);
  assign stat_o.room_zero   = (room_q == 5'd0);
  assign stat_o.scan_end    = (cur_q == SlotW'(Depth - 1));
  assign stat_o.pick_hit    = pick_q[cur_q];
  assign stat_o.pick_last   = ((pick_q & ~cur_bit) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q <= '0;
      used_q <= '0;
      soon_q <= CycMax;
      soon_slot_q <= CntW'(Depth);
      cur_q <= '0;
      pick_q <= '0;
    end else begin
      if (ctrl_i.do_alloc && free_f) begin
        valid_q[free_idx] <= 1'b1;
        done_q[free_idx] <= 1'b0;
        used_q <= used_q + 1'b1;
      end
      if (ctrl_i.do_fill && match_f) done_q[match_idx] <= 1'b1;
      if (ctrl_i.drain_pick) begin
        valid_q[cur_q] <= 1'b0;
        done_q[cur_q] <= 1'b0;
        used_q <= used_q - 1'b1;
      end
      if (ctrl_i.latch) pick_q <= '0;
      else if (ctrl_i.drain_pick) pick_q[cur_q] <= 1'b1;
      else if (ctrl_i.emit_pick) pick_q[cur_q] <= 1'b0;
      if (ctrl_i.latch || ctrl_i.scan_clear) cur_q <= '0;
      else if (ctrl_i.drain_step || ctrl_i.scan_step || ctrl_i.emit_step)
        cur_q <= cur_q + 1'b1;
      if (ctrl_i.scan_clear) begin
        soon_q <= CycMax;
        soon_slot_q <= CntW'(Depth);
      end
      if (ctrl_i.scan_step && valid_q[cur_q] && done_q[cur_q] &&
          (soon_slot_q == CntW'(Depth) || rdy_q[cur_q] < soon_q)) begin
        soon_q <= rdy_q[cur_q];
        soon_slot_q <= {1'b0, cur_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q <= op_i; a_q <= block_address_i; d_q <= fill_data_i;
      m_q <= prefetch_meta_i; req_q <= request_ready_cycle_i;
      now_q <= now_cycle_i;
      room_q <= (queue_room_i > 5'd16) ? 5'd16 : queue_room_i;
    end
    if (ctrl_i.drain_pick) room_q <= room_q - 1'b1;
    if (ctrl_i.do_alloc && free_f) begin
      addr_q[free_idx] <= a_q; meta_q[free_idx] <= m_q;
      data_q[free_idx] <= '0; rdy_q[free_idx] <= req_q;
    end
    if (ctrl_i.do_fill && match_f) begin
      data_q[match_idx] <= d_q; meta_q[match_idx] <= m_q;
      rdy_q[match_idx] <= newrdy;
    end
    // result payload
    if (ctrl_i.do_alloc) begin
      outcome_o <= free_f ? OutAlloc : OutFull;
      slot_o <= free_f ? free_idx : '0;
      entry_address_o <= a_q; entry_data_o <= '0; entry_meta_o <= '0;
      entry_ready_cycle_o <= free_f ? req_q : '0;
    end
    if (ctrl_i.do_fill) begin
      outcome_o <= match_f ? OutFillOk : OutFillMiss;
      slot_o <= match_f ? match_idx : '0;
      entry_address_o <= a_q; entry_data_o <= '0; entry_meta_o <= '0;
      entry_ready_cycle_o <= match_f ? newrdy : '0;
    end
    if (ctrl_i.emit_pick) begin
      outcome_o <= OutDrained; slot_o <= cur_q;
      entry_address_o <= addr_q[cur_q]; entry_data_o <= data_q[cur_q];
      entry_meta_o <= meta_q[cur_q]; entry_ready_cycle_o <= rdy_q[cur_q];
    end
    if (ctrl_i.latch) begin
      outcome_o <= OutNone; slot_o <= '0; entry_address_o <= '0;
      entry_data_o <= '0; entry_meta_o <= '0; entry_ready_cycle_o <= '0;
    end
  end

  assign entries_used_o   = used_q;
  assign earliest_ready_o = soon_q;
  assign earliest_slot_o  = soon_slot_q;
endmodule
`default_nettype wire

### rtl/mshr_control.sv
`timescale 1ns / 1ps
`default_nettype none
module mshr_control
  import mshr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output logic       busy_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       valid_o,
  output logic       last_o
);
  // drained slots are marked first and shown once the min scan has finished
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DRAIN, S_SCAN, S_EMIT, S_OUT
  } state_e;
  state_e state_q;
  logic   any_q;
  logic   drain_exit;

  assign drain_exit = stat_i.drain_end || (stat_i.drain_hit && !stat_i.room_left);

  always_comb begin
    ctrl_o = '0;
    ctrl_o.latch = (state_q == S_IDLE) && start_i;
    unique case (state_q)
      S_EXEC: begin
        ctrl_o.do_alloc = (stat_i.op == OpAlloc);
        ctrl_o.do_fill  = (stat_i.op == OpFill);
        ctrl_o.scan_clear = (stat_i.op == OpFill) && stat_i.match_found;
      end
      S_DRAIN: begin
        ctrl_o.drain_pick = stat_i.drain_hit;
        ctrl_o.drain_step = 1'b1;
        ctrl_o.scan_clear = drain_exit && (stat_i.drain_hit || any_q);
      end
      S_SCAN: ctrl_o.scan_step = 1'b1;
      S_OUT: begin
        ctrl_o.emit_pick = stat_i.pick_hit;
        ctrl_o.emit_step = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_o <= 1'b0; last_o <= 1'b0; any_q <= 1'b0;
    end else begin
      valid_o <= 1'b0; last_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_EXEC;
        S_EXEC: begin
          any_q <= 1'b0;
          if (stat_i.op == OpAlloc) begin
            valid_o <= 1'b1; last_o <= 1'b1; state_q <= S_IDLE;
          end else if (stat_i.op == OpFill) begin
            if (stat_i.match_found) state_q <= S_SCAN;
            else begin valid_o <= 1'b1; last_o <= 1'b1; state_q <= S_IDLE; end
          end else if (stat_i.op == OpDrain && !stat_i.room_zero) begin
            state_q <= S_DRAIN;
          end else begin
            valid_o <= 1'b1; last_o <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (stat_i.drain_hit) any_q <= 1'b1;
          if (drain_exit) begin
            state_q <= S_IDLE;
            if (stat_i.drain_hit || any_q) state_q <= S_SCAN;
            else begin valid_o <= 1'b1; last_o <= 1'b1; end
          end
        end
        S_SCAN: begin
          if (stat_i.scan_end) state_q <= (stat_i.op == OpDrain) ? S_OUT : S_EMIT;
        end
        S_EMIT: begin
          valid_o <= 1'b1; last_o <= 1'b1; state_q <= S_IDLE;
        end
        S_OUT: begin
          if (stat_i.pick_hit) begin
            valid_o <= 1'b1;
            if (stat_i.pick_last) begin
              last_o <= 1'b1; state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/mshr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mshr_checker
  import mshr_pkg::*;
(
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           result_valid_o,
  input wire logic           last_o,
  input wire logic [CntW-1:0] entries_used_o,
  input wire logic [CntW-1:0] earliest_slot_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request not taken");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without strobe");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_used_o <= CntW'(Depth)) else $error("occupancy overflow");
  a_soon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> earliest_slot_o <= CntW'(Depth))
    else $error("bad earliest slot");
endmodule
bind miss_status_holding_table mshr_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .result_valid_o, .last_o,
  .entries_used_o, .earliest_slot_o
);
`default_nettype wire

### tb/miss_status_holding_table_checker.sv
`timescale 1ns / 1ps
module miss_status_holding_table_checker
  import mshr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel_i,
  input  wire logic             penable_i,
  input  wire logic             pwrite_i,
  input  wire logic [0:0]       paddr_i,
  input  wire logic [31:0]      pwdata_i,
  input  wire logic             pready_i,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire logic [1:0]       op_i,
  input  wire logic [AddrW-1:0] block_address_i,
  input  wire logic [DataW-1:0] fill_data_i,
  input  wire logic [MetaW-1:0] prefetch_meta_i,
  input  wire logic [CycW-1:0]  request_ready_cycle_i,
  input  wire logic [CycW-1:0]  now_cycle_i,
  input  wire logic [4:0]       queue_room_i,
  input  wire logic             result_valid_i,
  input  wire logic [2:0]       outcome_i,
  input  wire logic [SlotW-1:0] slot_i,
  input  wire logic [AddrW-1:0] entry_address_i,
  input  wire logic [DataW-1:0] entry_data_i,
  input  wire logic [MetaW-1:0] entry_meta_i,
  input  wire logic [CycW-1:0]  entry_ready_cycle_i,
  input  wire logic [CntW-1:0]  entries_used_i,
  input  wire logic [CycW-1:0]  earliest_ready_i,
  input  wire logic [CntW-1:0]  earliest_slot_i,
  input  wire logic             last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [2:0]       outcome;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [MetaW-1:0] meta;
    logic [CycW-1:0]  ready;
    logic [CntW-1:0]  used;
    logic [CycW-1:0]  soon_cyc;
    logic [CntW-1:0]  soon_slot;
    logic             last;
  } miss_result_t;

  miss_result_t     awaited_results[$];
  logic             valid_q[Depth];
  logic             done_q[Depth];
  logic [AddrW-1:0] addr_q[Depth];
  logic [DataW-1:0] data_q[Depth];
  logic [MetaW-1:0] meta_q[Depth];
  logic [CycW-1:0]  ready_q[Depth];
  logic [CntW-1:0]  used_q;
  logic [CycW-1:0]  soon_cyc_q;
  logic [CntW-1:0]  soon_slot_q;
  logic [7:0]       fill_latency_q;

  assign pending_o = awaited_results.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic find_soonest();
    soon_cyc_q  = CycMax;
    soon_slot_q = CntW'(Depth);
    for (int i = 0; i < Depth; i++) begin
      if (valid_q[i] && done_q[i] &&
          (soon_slot_q == CntW'(Depth) || ready_q[i] < soon_cyc_q)) begin
        soon_cyc_q  = ready_q[i];
        soon_slot_q = CntW'(i);
      end
    end
  endtask

  task automatic predict_request();
    miss_result_t batch[$];
    miss_result_t r;
    int           idx;
    int           limit;
    logic [CycW:0] sum;
    logic [CycW-1:0] base;
    idx = -1;
    r   = '0;
    case (op_i)
      OpAlloc: begin
        for (int i = Depth - 1; i >= 0; i--) if (!valid_q[i]) idx = i;
        r.addr = block_address_i;
        if (idx >= 0) begin
          valid_q[idx] = 1'b1;
          done_q[idx]  = 1'b0;
          addr_q[idx]  = block_address_i;
          meta_q[idx]  = prefetch_meta_i;
          data_q[idx]  = '0;
          ready_q[idx] = request_ready_cycle_i;
          used_q++;
          r.outcome = OutAlloc;
          r.slot    = SlotW'(idx);
          r.ready   = request_ready_cycle_i;
        end else begin
          r.outcome = OutFull;
        end
        batch.push_back(r);
      end
      OpFill: begin
        for (int i = Depth - 1; i >= 0; i--)
          if (valid_q[i] && !done_q[i] && addr_q[i] == block_address_i) idx = i;
        r.addr = block_address_i;
        if (idx >= 0) begin
          base = (ready_q[idx] < now_cycle_i) ? now_cycle_i : ready_q[idx];
          sum  = {1'b0, base} + {{(CycW-7){1'b0}}, fill_latency_q};
          if (sum > {1'b0, CycMax}) sum = {1'b0, CycMax};
          done_q[idx]  = 1'b1;
          data_q[idx]  = fill_data_i;
          meta_q[idx]  = prefetch_meta_i;
          ready_q[idx] = sum[CycW-1:0];
          find_soonest();
          r.outcome = OutFillOk;
          r.slot    = SlotW'(idx);
          r.ready   = sum[CycW-1:0];
        end else begin
          r.outcome = OutFillMiss;
        end
        batch.push_back(r);
      end
      OpDrain: begin
        limit = (queue_room_i > Depth) ? Depth : int'(queue_room_i);
        for (int i = 0; i < Depth && batch.size() < limit; i++) begin
          if (valid_q[i] && done_q[i]) begin
            r = '0;
            r.outcome = OutDrained;
            r.slot    = SlotW'(i);
            r.addr    = addr_q[i];
            r.data    = data_q[i];
            r.meta    = meta_q[i];
            r.ready   = ready_q[i];
            batch.push_back(r);
            valid_q[i] = 1'b0;
            done_q[i]  = 1'b0;
            used_q--;
          end
        end
        if (batch.size() > 0) find_soonest();
        else begin
          r.outcome = OutNone;
          batch.push_back(r);
        end
      end
      default: begin
        r.outcome = OutNone;
        batch.push_back(r);
      end
    endcase
    foreach (batch[k]) begin
      batch[k].used      = used_q;
      batch[k].soon_cyc  = soon_cyc_q;
      batch[k].soon_slot = soon_slot_q;
      batch[k].last      = (k == batch.size() - 1);
      awaited_results.push_back(batch[k]);
    end
  endtask

  task automatic compare_result();
    miss_result_t w;
    if (awaited_results.size() == 0) begin
      report("unexpected result", 64'(outcome_i), 64'd0);
      return;
    end
    w = awaited_results.pop_front();
    if (outcome_i != w.outcome) report("outcome", outcome_i, w.outcome);
    if (slot_i != w.slot) report("slot", slot_i, w.slot);
    if (entry_address_i != w.addr) report("entry_address", entry_address_i, w.addr);
    if (entry_data_i != w.data) report("entry_data", entry_data_i, w.data);
    if (entry_meta_i != w.meta) report("entry_meta", entry_meta_i, w.meta);
    if (entry_ready_cycle_i != w.ready) report("entry_ready_cycle", entry_ready_cycle_i, w.ready);
    if (entries_used_i != w.used) report("entries_used", entries_used_i, w.used);
    if (earliest_ready_i != w.soon_cyc) report("earliest_ready", earliest_ready_i, w.soon_cyc);
    if (earliest_slot_i != w.soon_slot) report("earliest_slot", earliest_slot_i, w.soon_slot);
    if (last_i != w.last) report("last", last_i, w.last);
  endtask

  initial begin
    fail_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        valid_q[i] = 1'b0;
        done_q[i]  = 1'b0;
        addr_q[i]  = '0;
        data_q[i]  = '0;
        meta_q[i]  = '0;
        ready_q[i] = '0;
      end
      used_q         = '0;
      soon_cyc_q     = CycMax;
      soon_slot_q    = CntW'(Depth);
      fill_latency_q = 8'd10;
      awaited_results.delete();
    end else begin
      if (result_valid_i) compare_result();
      if (start_i && !busy_i) predict_request();
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 1'b0)
        fill_latency_q = pwdata_i[7:0];
    end
  end

endmodule

### tb/miss_status_holding_table_test.sv
`timescale 1ns / 1ps
module miss_status_holding_table_test;
  import mshr_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [0:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [1:0]       op_i = OpAlloc;
  logic [AddrW-1:0] block_address_i = '0;
  logic [DataW-1:0] fill_data_i = '0;
  logic [MetaW-1:0] prefetch_meta_i = '0;
  logic [CycW-1:0]  request_ready_cycle_i = '0;
  logic [CycW-1:0]  now_cycle_i = '0;
  logic [4:0]       queue_room_i = '0;
  logic             result_valid_o;
  logic [2:0]       outcome_o;
  logic [SlotW-1:0] slot_o;
  logic [AddrW-1:0] entry_address_o;
  logic [DataW-1:0] entry_data_o;
  logic [MetaW-1:0] entry_meta_o;
  logic [CycW-1:0]  entry_ready_cycle_o;
  logic [CntW-1:0]  entries_used_o;
  logic [CycW-1:0]  earliest_ready_o;
  logic [CntW-1:0]  earliest_slot_o;
  logic             last_o;
  int               fail_count;
  int               pending;
  int               idle_pct;
  logic [AddrW-1:0] addr_pool[8];

  always #10 clk_i = ~clk_i;

  miss_status_holding_table u_top (.*);

  miss_status_holding_table_checker u_checker (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .start_i, .busy_i(busy_o), .op_i, .block_address_i, .fill_data_i,
    .prefetch_meta_i, .request_ready_cycle_i, .now_cycle_i, .queue_room_i,
    .result_valid_i(result_valid_o), .outcome_i(outcome_o), .slot_i(slot_o),
    .entry_address_i(entry_address_o), .entry_data_i(entry_data_o),
    .entry_meta_i(entry_meta_o), .entry_ready_cycle_i(entry_ready_cycle_o),
    .entries_used_i(entries_used_o), .earliest_ready_i(earliest_ready_o),
    .earliest_slot_i(earliest_slot_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'(rand64());
  endfunction

  function automatic logic [CycW-1:0] rand_cycle();
    case ($urandom_range(3))
      0: return CycW'($urandom_range(255));
      1: return CycMax - CycW'($urandom_range(300));
      default: return CycW'(rand64());
    endcase
  endfunction

  // hold start with payload until the request is taken
  task automatic send(input logic [1:0] op, input logic [AddrW-1:0] addr,
                      input logic [DataW-1:0] data, input logic [MetaW-1:0] meta,
                      input logic [CycW-1:0] req, input logic [CycW-1:0] now,
                      input logic [4:0] room);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = op;
    block_address_i = addr;
    fill_data_i = data;
    prefetch_meta_i = meta;
    request_ready_cycle_i = req;
    now_cycle_i = now;
    queue_room_i = room;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic apb_write(input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 1'b0;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic quiesce();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_requests(input int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(15) == 0) addr_pool[$urandom_range(7)] = rand_addr();
      sel = $urandom_range(99);
      if (sel < 40)
        send(OpAlloc, addr_pool[$urandom_range(7)], rand64(), $urandom(),
             rand_cycle(), rand_cycle(), 5'($urandom_range(16)));
      else if (sel < 75)
        send(OpFill, ($urandom_range(9) == 0) ? rand_addr() : addr_pool[$urandom_range(7)],
             rand64(), $urandom(), rand_cycle(), rand_cycle(), 5'($urandom_range(16)));
      else if (sel < 95)
        send(OpDrain, rand_addr(), rand64(), $urandom(), rand_cycle(), rand_cycle(),
             5'($urandom_range(16)));
      else
        send(2'd3, rand_addr(), rand64(), $urandom(), rand_cycle(), rand_cycle(),
             5'($urandom_range(31)));
    end
  endtask

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    foreach (addr_pool[i]) addr_pool[i] = rand_addr();
    idle_pct = 28;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, saturation, unmatched fill, unused op, drains
    send(OpAlloc, '1, '0, '1, CycMax, '0, 5'd0);
    send(OpAlloc, '0, '1, '0, '0, CycMax, 5'd16);
    send(OpFill, '1, '1, '1, '0, '0, 5'd0);
    send(OpFill, 58'h123, '1, '0, '0, '0, 5'd0);
    send(2'd3, '0, '0, '0, '0, '0, 5'd31);
    send(OpDrain, '0, '0, '0, '0, '0, 5'd0);
    send(OpDrain, '0, '0, '0, '0, '0, 5'd16);
    for (int i = 0; i < 16; i++)
      send(OpAlloc, addr_pool[i % 8], '0, $urandom(), rand_cycle(), '0, 5'd0);
    send(OpFill, addr_pool[0], rand64(), $urandom(), '0, CycMax - CycW'(3), 5'd0);
    send(OpDrain, '0, '0, '0, '0, '0, 5'd2);
    quiesce();

    apb_write(32'hFFFF_FFFF);
    random_requests(170);
    quiesce();
    idle_pct = 88;
    apb_write(32'd0);
    random_requests(170);
    quiesce();
    idle_pct = 0;
    apb_write($urandom());
    random_requests(160);
    quiesce();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
